FILE: hdl/double_hash_key_table_macros.svh
// Assertion macros for the hash table design.
`ifndef DOUBLE_HASH_KEY_TABLE_MACROS_SVH
`define DOUBLE_HASH_KEY_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define DHKT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`else
`define DHKT_ASSERT(label, clk, rst_n, prop)
`endif
`ifndef ASSERT_OFF
`define DHKT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DHKT_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: hdl/dhkt_pkg.sv
`default_nettype none
package dhkt_pkg;
  typedef enum logic [2:0] {
    StIdle,
    StHash,
    StReduce,
    StFold,
    StStep,
    StRead,
    StCheck,
    StOut
  } state_e;

  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  localparam logic FuncSearch = 1'b0;
  localparam logic FuncInsert = 1'b1;

  localparam logic CfgPrimeOne = 1'b0;
  localparam logic CfgPrimeTwo = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/double_hash_key_table.sv
// Flow: each key byte passes through a hash, reduce and fold step for both
//   hashes, one step then sets up the probe, and each probe is a memory read
//   and a compare. The result is held in the output state until it is taken.
// Throughput: one item at a time; a new item is taken only when idle, once the
//   last result has been taken.
// Reset: asynchronous, active low; all slots empty, count cleared, primes 31 and 37.
`default_nettype none
`include "double_hash_key_table_macros.svh"
module double_hash_key_table #(
  parameter int TABLE_SIZE    = 127,
  parameter int MAX_KEY_BYTES = 4,
  parameter int VALUE_BITS    = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // s_axis_tuser_i: func
  // s_axis_tdata_i: key_bytes, key_len, entry_value (zero padded)
  input  wire                        s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire  [0:0]                 s_axis_tuser_i,
  input  wire  [((8*MAX_KEY_BYTES+3+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // m_axis_tdata_o: status, found_value, slot_index, entry_count (zero padded)
  output logic                       m_axis_tvalid_o,
  input  wire                        m_axis_tready_i,
  output logic [((2+VALUE_BITS+$clog2(TABLE_SIZE)+$clog2(TABLE_SIZE+1)+7)/8)*8-1:0]
                                     m_axis_tdata_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [0:0]                 cfg_index_i,
  input  wire  [15:0]                cfg_data_i
);
  localparam int KeyW   = 8 * MAX_KEY_BYTES;
  localparam int LenW   = 3;
  localparam int IdxW   = $clog2(TABLE_SIZE);
  localparam int CntW   = $clog2(TABLE_SIZE + 1);
  localparam int OutRaw = 2 + VALUE_BITS + IdxW + CntW;
  localparam int OutW   = ((OutRaw + 7) / 8) * 8;
  localparam int ByteW  = $clog2(MAX_KEY_BYTES + 1);
  // h*prime + byte with h below the table size and a 16-bit prime.
  localparam int ProdW  = IdxW + 17;
  // The residue is found with a reciprocal multiplication: the quotient
  // estimate is at most one too small, so one compare and subtract finishes it.
  localparam int ShiftS = ProdW + IdxW;
  localparam logic [63:0] RecipFull = (64'd1 << ShiftS) / 64'(TABLE_SIZE);
  localparam logic [ProdW:0] RecipM = RecipFull[ProdW:0];

  // Configuration: the user must write only while idle; the block does not enforce it and is always ready.
  logic [15:0] prime1_q, prime2_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime1_q <= 16'd31;
      prime2_q <= 16'd37;
    end else if (cfg_valid_i) begin
      if (cfg_index_i[0] == dhkt_pkg::CfgPrimeOne) prime1_q <= cfg_data_i;
      else prime2_q <= cfg_data_i;
    end
  end

  dhkt_pkg::state_e state_q, state_d;

  logic             func_q;
  logic [KeyW-1:0]  key_q;
  logic [LenW-1:0]  len_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [ByteW-1:0] byte_q;
  logic [IdxW-1:0]  h1_q, h2_q, idx_q, step_q;
  logic [15:0]      p1_q, p2_q;
  logic [ProdW-1:0] prod1_q, prod2_q, quot1_q, quot2_q;
  logic [IdxW:0]    probes_q;
  logic [CntW-1:0]  count_q;
  logic [1:0]       status_q;
  logic [VALUE_BITS-1:0] found_q;
  logic [IdxW-1:0]  slot_q;
  logic             out_valid_q;

  logic [TABLE_SIZE-1:0] valid_q;
  logic [KeyW+LenW+VALUE_BITS-1:0] mem [TABLE_SIZE];
  logic [KeyW+LenW+VALUE_BITS-1:0] rd_q;
  logic                             rd_valid_q;

  logic [LenW-1:0] len_in;
  logic [KeyW-1:0] key_in;
  always_comb begin
    len_in = s_axis_tdata_i[KeyW +: LenW];
    if (len_in == '0) len_in = LenW'(1);
    if (int'(len_in) > MAX_KEY_BYTES) len_in = LenW'(MAX_KEY_BYTES);
    key_in = '0;
    for (int b = 0; b < MAX_KEY_BYTES; b++) begin
      if (b < int'(len_in)) key_in[8*b +: 8] = s_axis_tdata_i[8*b +: 8];
    end
  end

  // Horner form: h = (h*p + byte) mod N, one byte at a time, both
  // hashes side by side. The product is formed first, then the quotient
  // estimate, then the residue is folded back below N.
  logic [7:0]         cur_byte;
  logic [ProdW-1:0]   t1, t2;
  logic [2*ProdW:0]   q1_full, q2_full;
  logic [ProdW-1:0]   q1_w, q2_w;
  logic [IdxW:0]      r1_w, r2_w;
  logic [IdxW-1:0]    n1, n2;
  always_comb begin
    cur_byte = key_q[8*(int'(len_q) - 1 - int'(byte_q)) +: 8];
    t1 = ProdW'(h1_q) * ProdW'(p1_q) + ProdW'(cur_byte);
    t2 = ProdW'(h2_q) * ProdW'(p2_q) + ProdW'(cur_byte);
    q1_full = (2*ProdW+1)'(prod1_q) * (2*ProdW+1)'(RecipM);
    q2_full = (2*ProdW+1)'(prod2_q) * (2*ProdW+1)'(RecipM);
    q1_w = ProdW'(q1_full >> ShiftS);
    q2_w = ProdW'(q2_full >> ShiftS);
    r1_w = (IdxW+1)'(prod1_q - ProdW'(quot1_q * ProdW'(TABLE_SIZE)));
    r2_w = (IdxW+1)'(prod2_q - ProdW'(quot2_q * ProdW'(TABLE_SIZE)));
    n1 = (r1_w >= (IdxW+1)'(TABLE_SIZE)) ? IdxW'(r1_w - (IdxW+1)'(TABLE_SIZE)) :
         IdxW'(r1_w);
    n2 = (r2_w >= (IdxW+1)'(TABLE_SIZE)) ? IdxW'(r2_w - (IdxW+1)'(TABLE_SIZE)) :
         IdxW'(r2_w);
  end

  logic [IdxW:0] next_idx_w;
  logic [IdxW-1:0] next_idx;
  always_comb begin
    next_idx_w = {1'b0, idx_q} + {1'b0, step_q};
    next_idx = (next_idx_w >= (IdxW+1)'(TABLE_SIZE)) ?
               IdxW'(next_idx_w - (IdxW+1)'(TABLE_SIZE)) : IdxW'(next_idx_w);
  end

  logic key_hit;
  assign key_hit = rd_valid_q && (rd_q[KeyW +: LenW] == len_q) &&
                   (rd_q[KeyW-1:0] == key_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhkt_pkg::StIdle: if (s_axis_tvalid_i) state_d = dhkt_pkg::StHash;
      dhkt_pkg::StHash: state_d = dhkt_pkg::StReduce;
      dhkt_pkg::StReduce: state_d = dhkt_pkg::StFold;
      dhkt_pkg::StFold: begin
        if (byte_q == ByteW'(len_q - 1'b1)) state_d = dhkt_pkg::StStep;
        else state_d = dhkt_pkg::StHash;
      end
      dhkt_pkg::StStep: state_d = dhkt_pkg::StRead;
      dhkt_pkg::StRead: state_d = dhkt_pkg::StCheck;
      dhkt_pkg::StCheck: begin
        if (func_q == dhkt_pkg::FuncInsert) begin
          if (!rd_valid_q || probes_q == (IdxW+1)'(TABLE_SIZE - 1))
            state_d = dhkt_pkg::StOut;
          else state_d = dhkt_pkg::StRead;
        end else begin
          if (!rd_valid_q || key_hit || probes_q == (IdxW+1)'(TABLE_SIZE - 1))
            state_d = dhkt_pkg::StOut;
          else state_d = dhkt_pkg::StRead;
        end
      end
      dhkt_pkg::StOut: if (!out_valid_q) state_d = dhkt_pkg::StIdle;
      default: state_d = dhkt_pkg::StIdle;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    s_axis_tready_o = (state_q == dhkt_pkg::StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dhkt_pkg::StIdle;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      if (state_q == dhkt_pkg::StCheck && state_d == dhkt_pkg::StOut) begin
        out_valid_q <= 1'b1;
        if (func_q == dhkt_pkg::FuncInsert && !rd_valid_q) begin
          valid_q[idx_q] <= 1'b1;
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  logic [CntW-1:0] count_after;
  assign count_after = count_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dhkt_pkg::StIdle: begin
        func_q <= s_axis_tuser_i[0];
        key_q  <= key_in;
        len_q  <= len_in;
        val_q  <= s_axis_tdata_i[KeyW+LenW +: VALUE_BITS];
        byte_q <= '0;
        h1_q <= '0;
        h2_q <= '0;
        p1_q <= prime1_q;
        p2_q <= prime2_q;
      end
      dhkt_pkg::StHash: begin
        prod1_q <= t1;
        prod2_q <= t2;
      end
      dhkt_pkg::StReduce: begin
        quot1_q <= q1_w;
        quot2_q <= q2_w;
      end
      dhkt_pkg::StFold: begin
        h1_q <= n1;
        h2_q <= n2;
        byte_q <= byte_q + 1'b1;
      end
      dhkt_pkg::StStep: begin
        idx_q    <= h1_q;
        step_q   <= (h2_q == IdxW'(TABLE_SIZE - 1)) ? '0 : h2_q + 1'b1;
        probes_q <= '0;
        status_q <= (func_q == dhkt_pkg::FuncInsert) ? dhkt_pkg::StatusFull :
                    dhkt_pkg::StatusNotFound;
        found_q  <= '0;
        slot_q   <= '0;
      end
      dhkt_pkg::StRead: begin
        rd_q       <= mem[idx_q];
        rd_valid_q <= valid_q[idx_q];
      end
      dhkt_pkg::StCheck: begin
        if (func_q == dhkt_pkg::FuncInsert) begin
          if (!rd_valid_q) begin
            mem[idx_q] <= {val_q, len_q, key_q};
            status_q <= dhkt_pkg::StatusDone;
            slot_q <= idx_q;
          end
        end else if (rd_valid_q && key_hit) begin
          status_q <= dhkt_pkg::StatusDone;
          slot_q <= idx_q;
          found_q <= rd_q[KeyW+LenW +: VALUE_BITS];
        end
        idx_q <= next_idx;
        probes_q <= probes_q + 1'b1;
      end
      dhkt_pkg::StOut: ;
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = OutW'({count_after, slot_q, found_q, status_q});

  `DHKT_ASSERT(a_count_bound, clk_i, rst_ni, int'(count_q) <= TABLE_SIZE)
  `DHKT_ASSERT(a_busy_out, clk_i, rst_ni, out_valid_q |-> state_q == dhkt_pkg::StOut)
  `DHKT_ASSERT(a_no_take_busy, clk_i, rst_ni, (state_q != dhkt_pkg::StIdle) |-> !s_axis_tready_o)
endmodule
`default_nettype wire
